[rtl/core/sida_pkg.sv]
// Shared types, constants and the power-of-ten table for the decimal text converter.
package sida_pkg;

   // Field widths and the highest decimal digit position of a 64-bit magnitude.
   localparam int unsigned ValueWidth = 64;
   localparam int unsigned CharWidth  = 8;
   localparam int unsigned PosWidth   = 5;
   localparam int unsigned MaxPos     = 19;
   localparam int unsigned MaxDigit   = 9;
   localparam int unsigned WideWidth  = ValueWidth + 4;

   // Character codes.
   localparam logic [CharWidth-1:0] MinusChar = 8'h2D;
   localparam logic [CharWidth-1:0] ZeroChar  = 8'h30;
   localparam logic [CharWidth-1:0] NineChar  = 8'h39;

   // One queued number: its sign, magnitude and the position of its leading digit.
   typedef struct packed {
      logic                  neg;
      logic [ValueWidth-1:0] mag;
      logic [PosWidth-1:0]   top;
   } item_type;

   // Ten to the power of a digit position.
   function automatic logic [ValueWidth-1:0] pow10(input logic [PosWidth-1:0] pos);
      logic [ValueWidth-1:0] result;
      case (pos)
         5'd0:    result = 64'd1;
         5'd1:    result = 64'd10;
         5'd2:    result = 64'd100;
         5'd3:    result = 64'd1000;
         5'd4:    result = 64'd10000;
         5'd5:    result = 64'd100000;
         5'd6:    result = 64'd1000000;
         5'd7:    result = 64'd10000000;
         5'd8:    result = 64'd100000000;
         5'd9:    result = 64'd1000000000;
         5'd10:   result = 64'd10000000000;
         5'd11:   result = 64'd100000000000;
         5'd12:   result = 64'd1000000000000;
         5'd13:   result = 64'd10000000000000;
         5'd14:   result = 64'd100000000000000;
         5'd15:   result = 64'd1000000000000000;
         5'd16:   result = 64'd10000000000000000;
         5'd17:   result = 64'd100000000000000000;
         5'd18:   result = 64'd1000000000000000000;
         5'd19:   result = 64'd10000000000000000000;
         default: result = '0;
      endcase
      return result;
   endfunction

endpackage

[rtl/core/sida_front.sv]
// Front end: takes numbers, forms sign and magnitude, and finds the leading digit position.
module sida_front (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic signed [sida_pkg::ValueWidth-1:0] req_value,
   output logic                                push,
   output sida_pkg::item_type                  push_item,
   input  logic                                q_full
);

   logic                            a_valid_ff;
   logic                            a_neg_ff;
   logic [sida_pkg::ValueWidth-1:0] a_mag_ff;
   logic [sida_pkg::MaxPos-1:0]     ge_vec;
   logic                            accept;

   // The stage holds when the queue is full.
   assign push      = a_valid_ff && !q_full;
   assign req_stall = a_valid_ff && q_full;
   assign accept    = req_valid && !req_stall;

   // Valid flag of the stage.
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (accept) begin
         a_valid_ff <= 1'b1;
      end else if (push) begin
         a_valid_ff <= 1'b0;
      end
   end

   // The magnitude is the unsigned two's complement negation of a negative value.
   always_ff @(posedge clock) begin
      if (accept) begin
         a_neg_ff <= req_value[sida_pkg::ValueWidth-1];
         a_mag_ff <= req_value[sida_pkg::ValueWidth-1] ?
                     (~req_value + sida_pkg::ValueWidth'(1)) : req_value;
      end
   end

   // Count the powers of ten not above the magnitude to locate the leading digit.
   always_comb begin
      for (int k = 1; k <= sida_pkg::MaxPos; k++) begin
         ge_vec[k-1] = a_mag_ff >= sida_pkg::pow10(sida_pkg::PosWidth'(k));
      end
   end

   assign push_item.neg = a_neg_ff;
   assign push_item.mag = a_mag_ff;
   assign push_item.top = sida_pkg::PosWidth'($countones(ge_vec));

endmodule

[rtl/core/sida_queue.sv]
// Short queue that decouples the front end from the digit generator.
module sida_queue #(
   parameter int Depth = 2
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  sida_pkg::item_type push_item,
   output logic               full,
   input  logic               pop,
   output logic               head_valid,
   output sida_pkg::item_type head_item
);

   localparam int PtrWidth   = $clog2(Depth);
   localparam int CountWidth = $clog2(Depth + 1);

   sida_pkg::item_type    entry_ff [Depth];
   logic [PtrWidth-1:0]   wr_ptr_ff;
   logic [PtrWidth-1:0]   rd_ptr_ff;
   logic [CountWidth-1:0] count_ff;

   assign full       = count_ff == CountWidth'(Depth);
   assign head_valid = count_ff != '0;
   assign head_item  = entry_ff[rd_ptr_ff];

   // Pointers and fill count.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PtrWidth'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PtrWidth'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

[rtl/core/sida_back.sv]
// Back end: any sign, then one decimal digit per cycle unless stalled, leading first.
module sida_back (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               head_valid,
   input  sida_pkg::item_type                 head_item,
   output logic                               pop,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [sida_pkg::CharWidth-1:0]     rsp_character,
   output logic                               rsp_last
);

   logic                            started_ff;
   logic [sida_pkg::ValueWidth-1:0] mag_ff;
   logic [sida_pkg::PosWidth-1:0]   pos_ff;
   logic                            rsp_valid_ff;
   logic [sida_pkg::CharWidth-1:0]  rsp_character_ff;
   logic                            rsp_last_ff;

   logic                            adv;
   logic                            fire;
   logic                            emit_minus;
   logic                            is_last;
   logic [sida_pkg::ValueWidth-1:0] cur_mag;
   logic [sida_pkg::PosWidth-1:0]   cur_pos;
   logic [sida_pkg::WideWidth-1:0]  mult [sida_pkg::MaxDigit+1];
   logic [sida_pkg::MaxDigit-1:0]   ge_vec;
   logic [3:0]                      digit;
   logic [sida_pkg::ValueWidth-1:0] rem;

   // The output register moves when it is empty or its transfer completes.
   assign adv  = !rsp_valid_ff || !rsp_stall;
   assign fire = adv && head_valid;

   // Work on the queue head; progress on it lives in the working registers.
   assign cur_mag    = started_ff ? mag_ff : head_item.mag;
   assign cur_pos    = started_ff ? pos_ff : head_item.top;
   assign emit_minus = head_item.neg && !started_ff;
   assign is_last    = !emit_minus && (cur_pos == '0);
   assign pop        = fire && is_last;

   // Digit at the current position: how many multiples of its power of ten fit.
   always_comb begin
      for (int j = 0; j <= sida_pkg::MaxDigit; j++) begin
         mult[j] = {4'b0, sida_pkg::pow10(cur_pos)} * sida_pkg::WideWidth'(j);
      end
      for (int j = 1; j <= sida_pkg::MaxDigit; j++) begin
         ge_vec[j-1] = {4'b0, cur_mag} >= mult[j];
      end
      digit = 4'($countones(ge_vec));
      rem   = cur_mag - mult[digit][sida_pkg::ValueWidth-1:0];
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         started_ff   <= 1'b0;
      end else begin
         if (adv) begin
            rsp_valid_ff <= head_valid;
         end
         if (fire) begin
            started_ff <= !is_last;
         end
      end
   end

   // Output character and working remainder.
   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_last_ff <= is_last;
         if (emit_minus) begin
            rsp_character_ff <= sida_pkg::MinusChar;
            mag_ff           <= head_item.mag;
            pos_ff           <= head_item.top;
         end else begin
            rsp_character_ff <= sida_pkg::ZeroChar + {4'b0, digit};
            mag_ff           <= rem;
            pos_ff           <= cur_pos - 1'b1;
         end
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_character = rsp_character_ff;
   assign rsp_last      = rsp_last_ff;

endmodule

[rtl/core/signed_int_to_decimal_ascii.sv]
// A number's first character passes the front-end stage, the queue and the back end's
// output register before it is offered. Throughput: one character per cycle unless
// stalled, set by the single output register; a number's text is 1 to 20 characters.
// A queue of QUEUE_DEPTH numbers lets the front end take numbers while digits go out.
// Reset (synchronous, active high) empties the pipeline and the queue.
module signed_int_to_decimal_ascii #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic signed [sida_pkg::ValueWidth-1:0] req_value,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic [sida_pkg::CharWidth-1:0]         rsp_character,
   output logic                                   rsp_last
);

   logic               push;
   logic               pop;
   logic               q_full;
   logic               head_valid;
   sida_pkg::item_type push_item;
   sida_pkg::item_type head_item;

   // Sign, magnitude and leading digit position.
   sida_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_value (req_value),
      .push      (push),
      .push_item (push_item),
      .q_full    (q_full)
   );

   // Decoupling queue.
   sida_queue #(
      .Depth (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_item  (push_item),
      .full       (q_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_item  (head_item)
   );

   // Character generation.
   sida_back u_back (
      .clock         (clock),
      .reset         (reset),
      .head_valid    (head_valid),
      .head_item     (head_item),
      .pop           (pop),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_character (rsp_character),
      .rsp_last      (rsp_last)
   );

endmodule

[rtl/core/sida_checker.sv]
// Port-level checks for the decimal text converter and their binding to it.
module sida_checker (
   input logic                                   clock,
   input logic                                   reset,
   input logic                                   req_valid,
   input logic                                   req_stall,
   input logic signed [sida_pkg::ValueWidth-1:0] req_value,
   input logic                                   rsp_valid,
   input logic                                   rsp_stall,
   input logic [sida_pkg::CharWidth-1:0]         rsp_character,
   input logic                                   rsp_last
);

   // A stalled character holds until its transfer.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_character) && $stable(rsp_last))
      else $error("stalled character changed");

   // Every character is a minus sign or a decimal digit.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_character == sida_pkg::MinusChar) ||
                    ((rsp_character >= sida_pkg::ZeroChar) &&
                     (rsp_character <= sida_pkg::NineChar)))
      else $error("character out of range");

   // A minus sign is always followed by digits.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_character == sida_pkg::MinusChar) |-> !rsp_last)
      else $error("minus sign marked last");

   // After a minus sign transfer the next character is a digit other than zero.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && (rsp_character == sida_pkg::MinusChar) |=>
         !rsp_valid || ((rsp_character > sida_pkg::ZeroChar) &&
                        (rsp_character <= sida_pkg::NineChar)))
      else $error("bad digit after minus sign");

   // Nothing is offered right after reset.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("character offered out of reset");

endmodule

bind signed_int_to_decimal_ascii sida_checker u_checker (.*);

[sim/decimal_text_checker.sv]
// Checker that predicts the decimal text of each accepted number and compares every character.
`timescale 1ns / 1ps

module decimal_text_checker (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   input  logic                                   req_stall,
   input  logic signed [sida_pkg::ValueWidth-1:0] req_value,
   input  logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   input  logic [sida_pkg::CharWidth-1:0]         rsp_character,
   input  logic                                   rsp_last,
   output int unsigned                            fail_count,
   output int unsigned                            pending_count
);

   // One expected character of a number's text.
   typedef struct packed {
      logic [sida_pkg::CharWidth-1:0] character;
      logic                           last;
   } text_char_type;

   text_char_type expected_text [$];

   initial begin
      fail_count    = 0;
      pending_count = 0;
   end

   // Append the decimal text of one number to the expected characters.
   function automatic void queue_decimal_text(input logic [sida_pkg::ValueWidth-1:0] value);
      logic [sida_pkg::ValueWidth-1:0] magnitude;
      logic [sida_pkg::CharWidth-1:0]  digits [20];
      int                              count;
      text_char_type                   entry;
      magnitude = value[sida_pkg::ValueWidth-1] ? (~value + 64'd1) : value;
      count     = 0;
      // Peel digits off the low end; they come out least significant first.
      do begin
         digits[count] = sida_pkg::ZeroChar + 8'(magnitude % 64'd10);
         count++;
         magnitude = magnitude / 64'd10;
      end while (magnitude != 0 && count < 20);
      if (value[sida_pkg::ValueWidth-1]) begin
         entry.character = sida_pkg::MinusChar;
         entry.last      = 1'b0;
         expected_text.push_back(entry);
      end
      while (count > 0) begin
         count--;
         entry.character = digits[count];
         entry.last      = (count == 0);
         expected_text.push_back(entry);
      end
   endfunction

   // Watch both channels; a number's transfer is predicted before any character is matched.
   always @(posedge clock) begin
      text_char_type want;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            queue_decimal_text(req_value);
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_text.size() == 0) begin
               $error("unexpected character transfer: character 0x%02h, last %0b",
                      rsp_character, rsp_last);
               fail_count++;
            end else begin
               want = expected_text.pop_front();
               if (rsp_character !== want.character) begin
                  $error("character: expected 0x%02h, actual 0x%02h",
                         want.character, rsp_character);
                  fail_count++;
               end
               if (rsp_last !== want.last) begin
                  $error("last: expected %0b, actual %0b", want.last, rsp_last);
                  fail_count++;
               end
            end
         end
      end
      pending_count = expected_text.size();
   end

endmodule

[sim/testbench.sv]
// Top of the testbench: clock, reset, number stimulus, receiver stalls and the verdict.
`timescale 1ns / 1ps

module testbench;

   localparam int DirectedCount = 23;
   localparam int RandomCount   = 137;
   localparam int TotalCount    = DirectedCount + RandomCount;
   localparam int PauseAt       = DirectedCount + 80;
   localparam int HoldAt        = 40;
   localparam int HoldCycles    = 300;
   localparam int DrainCycles   = 20;
   localparam int CycleLimit    = 200000;

   logic                                   clock = 1'b0;
   logic                                   reset = 1'b1;
   logic                                   req_valid = 1'b0;
   logic                                   req_stall;
   logic signed [sida_pkg::ValueWidth-1:0] req_value = '0;
   logic                                   rsp_valid;
   logic                                   rsp_stall = 1'b0;
   logic [sida_pkg::CharWidth-1:0]         rsp_character;
   logic                                   rsp_last;
   int unsigned                            fail_count;
   int unsigned                            pending_count;
   int                                     accepted_count = 0;
   int                                     cycle_count = 0;

   signed_int_to_decimal_ascii u_top (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_value     (req_value),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_character (rsp_character),
      .rsp_last      (rsp_last)
   );

   decimal_text_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_value     (req_value),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_character (rsp_character),
      .rsp_last      (rsp_last),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Ten raised to a small power, for picking magnitudes of a chosen digit count.
   function automatic logic [63:0] ten_power(input int n);
      logic [63:0] p;
      p = 64'd1;
      repeat (n) p = p * 64'd10;
      return p;
   endfunction

   // Fixed numbers: zero, single digits, decade edges and both ends of the range.
   function automatic logic [63:0] directed_value(input int idx);
      case (idx)
         0:       return 64'd0;
         1:       return 64'd1;
         2:       return -64'sd1;
         3:       return 64'd9;
         4:       return -64'sd9;
         5:       return 64'd10;
         6:       return -64'sd10;
         7:       return 64'd99;
         8:       return 64'd100;
         9:       return 64'd12345;
         10:      return -64'sd7;
         11:      return 64'h7FFF_FFFF_FFFF_FFFF;
         12:      return 64'h8000_0000_0000_0000;
         13:      return 64'h8000_0000_0000_0001;
         14:      return 64'h7FFF_FFFF_FFFF_FFFE;
         15:      return 64'd1000000000000000000;
         16:      return -64'sd1000000000000000000;
         17:      return 64'd999999999999999999;
         18:      return -64'sd999999999999999999;
         19:      return 64'h5555_5555_5555_5555;
         20:      return 64'hAAAA_AAAA_AAAA_AAAA;
         21:      return 64'd4294967296;
         default: return -64'sd4294967295;
      endcase
   endfunction

   // Random numbers: raw bit patterns, chosen digit counts, range ends and decade edges.
   function automatic logic [63:0] random_value();
      logic [63:0] magnitude;
      logic [63:0] low_end;
      logic [63:0] span;
      int          kind;
      int          n;
      int          offset;
      kind = $urandom_range(0, 5);
      case (kind)
         2, 3: begin
            n       = $urandom_range(1, 19);
            low_end = ten_power(n - 1);
            span    = (n == 19) ? (64'h8000_0000_0000_0000 - low_end)
                                : (ten_power(n) - low_end);
            magnitude = low_end + ({$urandom, $urandom} % span);
            return ($urandom_range(0, 1) != 0) ? -magnitude : magnitude;
         end
         4: begin
            offset = $urandom_range(0, 20);
            case ($urandom_range(0, 3))
               0:       return 64'h8000_0000_0000_0000 + offset;
               1:       return 64'h7FFF_FFFF_FFFF_FFFF - offset;
               2:       return offset;
               default: return -offset;
            endcase
         end
         5: begin
            magnitude = ten_power($urandom_range(0, 18)) + $urandom_range(0, 2) - 1;
            return ($urandom_range(0, 1) != 0) ? -magnitude : magnitude;
         end
         default: return {$urandom, $urandom};
      endcase
   endfunction

   // Offer one number and hold it until its transfer.
   task automatic offer_number(input logic [63:0] value);
      req_valid <= 1'b1;
      req_value <= value;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      accepted_count++;
   endtask

   // Wait, on the falling edge, until every predicted character has arrived.
   task automatic wait_text_drained();
      do @(negedge clock); while (pending_count != 0);
      @(posedge clock);
   endtask

   // Receiver: stall patterns that change in stretches, plus one long hold-off.
   initial begin
      int  mode;
      int  span;
      bit  hold_done;
      bit  toggle;
      hold_done = 1'b0;
      toggle    = 1'b0;
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         if (!hold_done && accepted_count >= HoldAt) begin
            hold_done = 1'b1;
            rsp_stall <= 1'b1;
            repeat (HoldCycles) @(posedge clock);
         end else begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(1, 60);
            repeat (span) begin
               toggle = ~toggle;
               case (mode)
                  0:       rsp_stall <= 1'b0;
                  1:       rsp_stall <= ($urandom_range(0, 1) != 0);
                  2:       rsp_stall <= ($urandom_range(0, 3) != 0);
                  default: rsp_stall <= toggle;
               endcase
               @(posedge clock);
            end
         end
      end
   end

   // Run-time limit.
   initial begin
      while (cycle_count < CycleLimit) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Test completed with failures");
      $finish;
   end

   // Sender: directed numbers, then random ones, in bursts with random gaps.
   initial begin
      int burst_left;
      int gap;
      burst_left = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      for (int i = 0; i < TotalCount; i++) begin
         // One pause with the input idle until the output has fully drained.
         if (i == PauseAt) begin
            req_valid  <= 1'b0;
            wait_text_drained();
            burst_left = 0;
         end
         if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 25);
            if (gap > 0) begin
               req_valid <= 1'b0;
               repeat (gap) @(posedge clock);
            end
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(1, 12);
         end
         offer_number((i < DirectedCount) ? directed_value(i) : random_value());
         burst_left--;
      end
      req_valid <= 1'b0;
      wait_text_drained();
      repeat (DrainCycles) @(posedge clock);
      if (fail_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
